// ----- rtl/polyline_cull_and_subdivide_macros.svh -----
// assertion macros for the checker file of polyline_cull_and_subdivide
`ifndef POLYLINE_CULL_AND_SUBDIVIDE_MACROS_SVH
`define POLYLINE_CULL_AND_SUBDIVIDE_MACROS_SVH

// condition and consequence checked at the same edge
`define PCS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence checked at the following edge
`define PCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/pcs_pkg.sv -----
// shared constants and types of the polyline cull and subdivide block
package pcs_pkg;

    // coordinate and arithmetic widths
    localparam int COORD_W  = 24;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int SUM_W    = 2 * DIFF_W;
    localparam int ROOT_W   = 26;
    localparam int RAD_W    = 2 * ROOT_W;
    localparam int DIV_W    = 16;
    localparam int REM_W    = ROOT_W + 2;

    // subdivision cap
    localparam int MAX_STEPS = 64;
    localparam int STEP_W    = $clog2(MAX_STEPS + 1);

    // iterative unit sequencing
    localparam int UNIT_STEPS = ROOT_W;
    localparam int CNT_W      = $clog2(UNIT_STEPS);

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 23;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_STEP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CULL_MARGIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CURVE_ID    = 2'd2;

    // register reset values
    localparam logic [15:0] PIXEL_STEP_RST  = 16'd66;
    localparam logic [22:0] CULL_MARGIN_RST = 23'd78643;

    // shared unit operations
    localparam logic OP_DIV  = 1'b0;
    localparam logic OP_SQRT = 1'b1;

    typedef struct packed {
        logic             start;
        logic             op;
        logic [RAD_W-1:0] operand;
        logic [DIV_W-1:0] divisor;
    } t_unit_req;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] result;
        logic [DIV_W-1:0]  rem;
    } t_unit_rsp;

endpackage

// ----- rtl/polyline_cull_and_subdivide.sv -----
// top level of the polyline cull and subdivide block
// Takes one signed Q8.16 point per transfer and emits the points of the segment from the
// previous point. A curve-start point is passed straight out and a culled segment is dropped.
// Any other segment needs its squared length (one shared 25x25 multiplier) and an integer
// square root on the shared iterative unit. A subdivided segment adds a ceiling divide for
// the step count and one divide each for x and y on the same unit, then gives one
// interpolated point per cycle while the output register is free; steps at most MAX_STEPS.
// The input side is ready only between items; results leave through an output register, so
// the next point is taken while the last result still waits.
module polyline_cull_and_subdivide (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [47:0]                         s_axis_tdata,  // point_x, point_y
    input  logic                                s_axis_tuser,  // curve_start
    // output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [63:0]                         m_axis_tdata,  // out_x, out_y, out_curve
    output logic                                m_axis_tlast,  // last_of_run
    // configuration writes
    input  logic                                i_cfg_we,
    input  logic [pcs_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [pcs_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHECK  = 4'd1;
    localparam logic [3:0] S_SQX    = 4'd2;
    localparam logic [3:0] S_SQY    = 4'd3;
    localparam logic [3:0] S_ROOTGO = 4'd4;
    localparam logic [3:0] S_ROOTW  = 4'd5;
    localparam logic [3:0] S_LEN    = 4'd6;
    localparam logic [3:0] S_CEILW  = 4'd7;
    localparam logic [3:0] S_DXGO   = 4'd8;
    localparam logic [3:0] S_DXW    = 4'd9;
    localparam logic [3:0] S_DYGO   = 4'd10;
    localparam logic [3:0] S_DYW    = 4'd11;
    localparam logic [3:0] S_EMIT   = 4'd12;
    localparam logic [3:0] S_ENDP   = 4'd13;

    localparam int CW = pcs_pkg::COORD_W;
    localparam int DW = pcs_pkg::DIFF_W;
    localparam int SW = pcs_pkg::STEP_W;

    // configuration registers
    logic [15:0]           r_pixel_step;
    logic [22:0]           r_cull_margin;
    logic [15:0]           r_curve_id;

    // sequencer and segment state
    logic [3:0]            r_state;
    logic [3:0]            n_state;
    logic [CW-1:0]         r_x1, r_y1, r_x2, r_y2;
    logic                  r_start;
    logic [DW-1:0]         r_ax, r_ay;
    logic                  r_negx, r_negy;
    logic [pcs_pkg::SUM_W-1:0]  r_sum;
    logic [pcs_pkg::ROOT_W-1:0] r_len;
    logic [SW-1:0]         r_steps;
    logic [SW-1:0]         r_k;
    logic [DW-1:0]         r_qdx, r_qdy, r_qx, r_qy;
    logic [SW-1:0]         r_rdx, r_rdy, r_rx, r_ry;

    // output register
    logic                  r_ov;
    logic [CW-1:0]         r_ox, r_oy;
    logic [15:0]           r_ocurve;
    logic                  r_olast;

    // unit handshake
    pcs_pkg::t_unit_req    unit_req;
    pcs_pkg::t_unit_rsp    unit_rsp;

    logic                  in_xfer;
    logic                  slot_free;
    logic                  emit;
    logic                  culled;
    logic                  len_gt;
    logic [15:0]           ps;
    logic [pcs_pkg::ROOT_W-1:0] ceil_num;
    logic [SW-1:0]         steps_clamped;
    logic signed [DW-1:0]  x1s, x2s, y1s, y2s, m_pos, m_neg;
    logic signed [DW-1:0]  maxx, minx, maxy, miny, dxs, dys;
    logic [DW-1:0]         mul_op;
    logic [pcs_pkg::SUM_W-1:0] prod;
    logic [SW:0]           rx_sum, ry_sum;
    logic                  cx, cy;
    logic [CW-1:0]         ix, iy;

    // saturate a 26-bit signed sum to the coordinate range
    function automatic logic [CW-1:0] sat_coord(input logic signed [DW:0] v);
        logic [CW-1:0] res;
        if (v > (DW+1)'(signed'({1'b0, {(CW-1){1'b1}}}))) begin
            res = {1'b0, {(CW-1){1'b1}}};
        end else if (v < -(DW+1)'(signed'({1'b0, 1'b1, {(CW-1){1'b0}}}))) begin
            res = {1'b1, {(CW-1){1'b0}}};
        end else begin
            res = v[CW-1:0];
        end
        return res;
    endfunction

    // point plus or minus the running quotient
    function automatic logic [CW-1:0] interp(input logic [CW-1:0] base,
                                            input logic [DW-1:0] q,
                                            input logic neg);
        logic signed [DW:0] b;
        logic signed [DW:0] d;
        b = signed'({{2{base[CW-1]}}, base});
        d = signed'({1'b0, q});
        return sat_coord(neg ? b - d : b + d);
    endfunction

    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign slot_free     = !r_ov || m_axis_tready;
    assign emit          = slot_free && ((r_state == S_EMIT) || (r_state == S_ENDP));

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_step  <= pcs_pkg::PIXEL_STEP_RST;
            r_cull_margin <= pcs_pkg::CULL_MARGIN_RST;
            r_curve_id    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pcs_pkg::REG_PIXEL_STEP:  r_pixel_step  <= i_cfg_data[15:0];
                pcs_pkg::REG_CULL_MARGIN: r_cull_margin <= i_cfg_data;
                pcs_pkg::REG_CURVE_ID:    r_curve_id    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // bounding box cull against the margin square
    always_comb begin
        x1s   = signed'({r_x1[CW-1], r_x1});
        x2s   = signed'({r_x2[CW-1], r_x2});
        y1s   = signed'({r_y1[CW-1], r_y1});
        y2s   = signed'({r_y2[CW-1], r_y2});
        m_pos = signed'({2'b00, r_cull_margin});
        m_neg = -m_pos;
        maxx  = (x1s > x2s) ? x1s : x2s;
        minx  = (x1s < x2s) ? x1s : x2s;
        maxy  = (y1s > y2s) ? y1s : y2s;
        miny  = (y1s < y2s) ? y1s : y2s;
        culled = (maxx < m_neg) || (minx > m_pos) || (maxy < m_neg) || (miny > m_pos);
        dxs   = x2s - x1s;
        dys   = y2s - y1s;
    end

    // shared squarer
    assign mul_op = (r_state == S_SQX) ? r_ax : r_ay;
    assign prod   = mul_op * mul_op;

    // length threshold and step count
    assign ps       = (r_pixel_step == 16'd0) ? 16'd1 : r_pixel_step;
    assign len_gt   = (r_len > {{(pcs_pkg::ROOT_W-16){1'b0}}, ps});
    assign ceil_num = r_len + {{(pcs_pkg::ROOT_W-16){1'b0}}, ps} - 1'b1;
    assign steps_clamped = (unit_rsp.result > pcs_pkg::ROOT_W'(pcs_pkg::MAX_STEPS))
                         ? SW'(pcs_pkg::MAX_STEPS) : unit_rsp.result[SW-1:0];

    // requests to the shared unit
    always_comb begin
        unit_req.start = (r_state == S_ROOTGO) || ((r_state == S_LEN) && len_gt)
                      || (r_state == S_DXGO) || (r_state == S_DYGO);
        unit_req.op    = (r_state == S_ROOTGO) ? pcs_pkg::OP_SQRT : pcs_pkg::OP_DIV;
        unit_req.divisor = (r_state == S_LEN) ? ps
                         : {{(pcs_pkg::DIV_W-SW){1'b0}}, r_steps};
        case (r_state)
            S_ROOTGO: unit_req.operand = {{(pcs_pkg::RAD_W-pcs_pkg::SUM_W){1'b0}}, r_sum};
            S_LEN:    unit_req.operand = {{(pcs_pkg::RAD_W-pcs_pkg::ROOT_W){1'b0}}, ceil_num};
            S_DXGO:   unit_req.operand = {{(pcs_pkg::RAD_W-DW){1'b0}}, r_ax};
            S_DYGO:   unit_req.operand = {{(pcs_pkg::RAD_W-DW){1'b0}}, r_ay};
            default:  unit_req.operand = '0;
        endcase
    end

    pcs_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (unit_req),
        .o_rsp   (unit_rsp)
    );

    // next interpolation quotient and remainder
    always_comb begin
        rx_sum = {1'b0, r_rx} + {1'b0, r_rdx};
        ry_sum = {1'b0, r_ry} + {1'b0, r_rdy};
        cx     = (rx_sum >= {1'b0, r_steps});
        cy     = (ry_sum >= {1'b0, r_steps});
        ix     = interp(r_x1, r_qx, r_negx);
        iy     = interp(r_y1, r_qy, r_negy);
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (in_xfer) n_state = S_CHECK;
            S_CHECK:  n_state = r_start ? S_ENDP : (culled ? S_IDLE : S_SQX);
            S_SQX:    n_state = S_SQY;
            S_SQY:    n_state = S_ROOTGO;
            S_ROOTGO: n_state = S_ROOTW;
            S_ROOTW:  if (unit_rsp.done) n_state = S_LEN;
            S_LEN:    n_state = len_gt ? S_CEILW : S_ENDP;
            S_CEILW:  if (unit_rsp.done) n_state = S_DXGO;
            S_DXGO:   n_state = S_DXW;
            S_DXW:    if (unit_rsp.done) n_state = S_DYGO;
            S_DYGO:   n_state = S_DYW;
            S_DYW:    if (unit_rsp.done) n_state = S_EMIT;
            S_EMIT:   if (emit && (r_k == r_steps - 1'b1)) n_state = S_ENDP;
            S_ENDP:   if (emit) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // control state and the held point
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_x2    <= '0;
            r_y2    <= '0;
        end else begin
            r_state <= n_state;
            if (in_xfer) begin
                r_x2 <= s_axis_tdata[CW-1:0];
                r_y2 <= s_axis_tdata[2*CW-1:CW];
            end
            if (emit) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // segment datapath
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_x1    <= r_x2;
            r_y1    <= r_y2;
            r_start <= s_axis_tuser;
        end
        if (r_state == S_CHECK) begin
            r_ax   <= dxs[DW-1] ? DW'(-dxs) : DW'(dxs);
            r_ay   <= dys[DW-1] ? DW'(-dys) : DW'(dys);
            r_negx <= dxs[DW-1];
            r_negy <= dys[DW-1];
        end
        if (r_state == S_SQX) r_sum <= prod;
        if (r_state == S_SQY) r_sum <= r_sum + prod;
        if ((r_state == S_ROOTW) && unit_rsp.done) r_len <= unit_rsp.result;
        if ((r_state == S_CEILW) && unit_rsp.done) r_steps <= steps_clamped;
        if ((r_state == S_DXW) && unit_rsp.done) begin
            r_qdx <= unit_rsp.result[DW-1:0];
            r_rdx <= unit_rsp.rem[SW-1:0];
        end
        if ((r_state == S_DYW) && unit_rsp.done) begin
            r_qdy <= unit_rsp.result[DW-1:0];
            r_rdy <= unit_rsp.rem[SW-1:0];
            r_qx  <= r_qdx;
            r_rx  <= r_rdx;
            r_qy  <= unit_rsp.result[DW-1:0];
            r_ry  <= unit_rsp.rem[SW-1:0];
            r_k   <= SW'(1);
        end
        // step to the next interpolated point
        if (emit && (r_state == S_EMIT)) begin
            r_k  <= r_k + 1'b1;
            r_qx <= r_qx + r_qdx + DW'(cx);
            r_qy <= r_qy + r_qdy + DW'(cy);
            r_rx <= cx ? SW'(rx_sum - {1'b0, r_steps}) : rx_sum[SW-1:0];
            r_ry <= cy ? SW'(ry_sum - {1'b0, r_steps}) : ry_sum[SW-1:0];
        end
    end

    // output register load
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_ocurve <= r_curve_id;
            if (r_state == S_EMIT) begin
                r_ox    <= ix;
                r_oy    <= iy;
                r_olast <= 1'b0;
            end else begin
                r_ox    <= r_x2;
                r_oy    <= r_y2;
                r_olast <= 1'b1;
            end
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {r_ocurve, r_oy, r_ox};
    assign m_axis_tlast  = r_olast;

endmodule

// ----- rtl/pcs_unit.sv -----
// shared iterative square root and divide unit, one result bit per cycle
module pcs_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pcs_pkg::t_unit_req  i_req,
    output pcs_pkg::t_unit_rsp  o_rsp
);

    logic                         r_busy;
    logic                         r_done;
    logic [pcs_pkg::CNT_W-1:0]    r_cnt;
    logic                         r_sqrt;
    logic [pcs_pkg::RAD_W-1:0]    r_acc;
    logic [pcs_pkg::REM_W-1:0]    r_rem;
    logic [pcs_pkg::ROOT_W-1:0]   r_res;
    logic [pcs_pkg::DIV_W-1:0]    r_den;

    logic [pcs_pkg::REM_W-1:0]    rem_sh;
    logic [pcs_pkg::REM_W-1:0]    trial;
    logic [pcs_pkg::REM_W-1:0]    diff;
    logic                         ge;

    // one compare and subtract step: two radicand bits or one dividend bit
    always_comb begin
        if (r_sqrt) begin
            rem_sh = {r_rem[pcs_pkg::REM_W-3:0], r_acc[pcs_pkg::RAD_W-1 -: 2]};
            trial  = {r_res, 2'b01};
        end else begin
            rem_sh = {r_rem[pcs_pkg::REM_W-2:0], r_acc[pcs_pkg::RAD_W-1]};
            trial  = {{(pcs_pkg::REM_W-pcs_pkg::DIV_W){1'b0}}, r_den};
        end
        ge   = (rem_sh >= trial);
        diff = rem_sh - trial;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == pcs_pkg::CNT_W'(pcs_pkg::UNIT_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_sqrt <= (i_req.op == pcs_pkg::OP_SQRT);
            r_rem  <= '0;
            r_res  <= '0;
            r_den  <= i_req.divisor;
            if (i_req.op == pcs_pkg::OP_SQRT) begin
                r_acc <= i_req.operand;
            end else begin
                r_acc <= {i_req.operand[pcs_pkg::ROOT_W-1:0], {pcs_pkg::ROOT_W{1'b0}}};
            end
        end else if (r_busy) begin
            r_rem <= ge ? diff : rem_sh;
            r_res <= {r_res[pcs_pkg::ROOT_W-2:0], ge};
            if (r_sqrt) begin
                r_acc <= {r_acc[pcs_pkg::RAD_W-3:0], 2'b00};
            end else begin
                r_acc <= {r_acc[pcs_pkg::RAD_W-2:0], 1'b0};
            end
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_res;
    assign o_rsp.rem    = r_rem[pcs_pkg::DIV_W-1:0];

endmodule

// ----- rtl/pcs_checker.sv -----
// port-level checker for polyline_cull_and_subdivide and its bind
`include "polyline_cull_and_subdivide_macros.svh"

module pcs_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [63:0]                         m_axis_tdata,
    input logic                                m_axis_tlast
);

    // a stalled result holds its value
    `PCS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
        "output changed while stalled")

    // one point at a time: the input side closes after a transfer
    `PCS_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready,
        "input taken while a point is in work")

    // an interpolated point means the run is still going, so no new input
    `PCS_ASSERT_SAME(a_run_open, m_axis_tvalid && !m_axis_tlast, !s_axis_tready,
        "input ready inside a run")

endmodule

bind polyline_cull_and_subdivide pcs_checker u_pcs_checker (.*);
